// ===== design/htfd_pkg.sv =====
package htfd_pkg;

	localparam int unsigned TempWidth = 15;
	localparam int unsigned HumWidth  = 14;
	localparam int unsigned WordWidth = 16;

	typedef logic [7:0]                   byte_t;
	typedef logic [WordWidth-1:0]         word_t;
	typedef logic signed [TempWidth-1:0]  temp_t;
	typedef logic [HumWidth-1:0]          hum_t;
	typedef logic [2:0]                   pos_t;

	localparam byte_t CrcStart = 8'hFF;
	localparam byte_t CrcPoly  = 8'h31;

	localparam pos_t PosTempHi  = 3'd0;
	localparam pos_t PosTempLo  = 3'd1;
	localparam pos_t PosTempCrc = 3'd2;
	localparam pos_t PosHumHi   = 3'd3;
	localparam pos_t PosHumLo   = 3'd4;
	localparam pos_t PosHumCrc  = 3'd5;

	localparam logic [TempWidth-1:0] TempSpan   = 15'd17500;
	localparam logic [TempWidth-1:0] TempOffset = 15'd4500;
	localparam logic [HumWidth-1:0]  HumSpan    = 14'd10000;
	localparam logic [WordWidth:0]   FullScale  = 17'd65535;

	function automatic byte_t crc8_feed(input byte_t crc, input byte_t b);
		byte_t c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== design/htfd_rx_if.sv =====
interface htfd_rx_if;
	import htfd_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;
	logic  frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== design/htfd_res_if.sv =====
interface htfd_res_if;
	import htfd_pkg::*;

	logic  valid;
	logic  ready;
	temp_t temperature_centi;
	hum_t  humidity_centi;
	logic  crc_error;

	modport source (output valid, output temperature_centi, output humidity_centi,
		output crc_error, input ready);
	modport sink   (input valid, input temperature_centi, input humidity_centi,
		input crc_error, output ready);
endinterface

// ===== design/humidity_temperature_frame_decoder.sv =====
// Channel | Dir | Payload                                          | Transaction
// rx      | in  | rx_byte[7:0], frame_start                        | valid && ready
// res     | out | temperature_centi[14:0] s, humidity_centi[13:0], | valid && ready
//         |     | crc_error                                        |
//
// One byte is taken per cycle while rx.ready is high. A result for the
// sixth byte of a frame passes the frame, multiplier and result registers.
// rx.ready falls only while all three stages hold a result and res is stalled.
// arst_n clears frame position, checksum and stage valid flags.
module humidity_temperature_frame_decoder (
	input logic       clk,
	input logic       arst_n,
	htfd_rx_if.sink   rx,
	htfd_res_if.source res
);
	import htfd_pkg::*;

	pos_t  pos_q;
	word_t temp_word_q;
	word_t hum_word_q;
	byte_t crc_q;
	logic  first_bad_q;

	logic  v_s1, v_s2, v_q;
	word_t temp_word_s1, hum_word_s1;
	logic  bad_s1, bad_s2;
	logic [TempWidth+WordWidth-1:0] temp_prod_s2;
	logic [HumWidth+WordWidth-1:0]  hum_prod_s2;
	temp_t temp_q;
	hum_t  hum_q;
	logic  bad_q;

	logic  out_free, s2_free, s1_free, rx_take;
	logic  restart;
	pos_t  eff_pos;
	byte_t crc_in, crc_next;
	logic  frame_done, frame_bad;

	assign out_free = !v_q || res.ready;
	assign s2_free  = !v_s2 || out_free;
	assign s1_free  = !v_s1 || s2_free;
	assign rx.ready = s1_free;
	assign rx_take  = rx.valid && rx.ready;

	assign restart    = rx.frame_start || (pos_q > PosHumCrc);
	assign eff_pos    = restart ? PosTempHi : pos_q;
	assign crc_in     = restart ? CrcStart : crc_q;
	assign crc_next   = crc8_feed(crc_in, rx.rx_byte);
	assign frame_done = rx_take && (eff_pos == PosHumCrc);
	assign frame_bad  = first_bad_q || (crc_in != rx.rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= PosTempHi;
			temp_word_q <= '0;
			hum_word_q  <= '0;
			crc_q       <= CrcStart;
			first_bad_q <= 1'b0;
		end else if (rx_take) begin
			pos_q <= (eff_pos == PosHumCrc) ? PosTempHi : eff_pos + 3'd1;
			unique case (eff_pos)
				PosTempHi: begin
					temp_word_q <= {rx.rx_byte, 8'h00};
					crc_q       <= crc_next;
				end
				PosTempLo: begin
					temp_word_q <= {temp_word_q[15:8], rx.rx_byte};
					crc_q       <= crc_next;
				end
				PosTempCrc: begin
					first_bad_q <= (crc_in != rx.rx_byte);
					crc_q       <= CrcStart;
				end
				PosHumHi: begin
					hum_word_q <= {rx.rx_byte, 8'h00};
					crc_q      <= crc_next;
				end
				PosHumLo: begin
					hum_word_q <= {hum_word_q[15:8], rx.rx_byte};
					crc_q      <= crc_next;
				end
				default: begin
					crc_q       <= CrcStart;
					first_bad_q <= 1'b0;
				end
			endcase
		end
	end

	// frame stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= frame_done;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && frame_done) begin
			temp_word_s1 <= temp_word_q;
			hum_word_s1  <= hum_word_q;
			bad_s1       <= frame_bad;
		end
	end

	// multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && v_s1) begin
			temp_prod_s2 <= (TempWidth+WordWidth)'(temp_word_s1) *
				(TempWidth+WordWidth)'(TempSpan);
			hum_prod_s2  <= (HumWidth+WordWidth)'(hum_word_s1) *
				(HumWidth+WordWidth)'(HumSpan);
			bad_s2       <= bad_s1;
		end
	end

	// divide by 65535: x = a*2^16 + b gives a + (a + b >= 65535)
	logic [TempWidth-1:0] t_hi, t_quot;
	logic [HumWidth-1:0]  h_hi, h_quot, h_clip;
	logic [WordWidth:0]   t_sum, h_sum;
	temp_t                t_val;

	always_comb begin
		t_hi   = temp_prod_s2[TempWidth+WordWidth-1:WordWidth];
		t_sum  = (WordWidth+1)'(t_hi) + (WordWidth+1)'(temp_prod_s2[WordWidth-1:0]);
		t_quot = t_hi + TempWidth'(t_sum >= FullScale);
		t_val  = temp_t'(t_quot - TempOffset);
		h_hi   = hum_prod_s2[HumWidth+WordWidth-1:WordWidth];
		h_sum  = (WordWidth+1)'(h_hi) + (WordWidth+1)'(hum_prod_s2[WordWidth-1:0]);
		h_quot = h_hi + HumWidth'(h_sum >= FullScale);
		h_clip = (h_quot > HumSpan) ? HumSpan : h_quot;
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (out_free) begin
			v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s2) begin
			temp_q <= bad_s2 ? '0 : t_val;
			hum_q  <= bad_s2 ? '0 : h_clip;
			bad_q  <= bad_s2;
		end
	end

	assign res.valid             = v_q;
	assign res.temperature_centi = temp_q;
	assign res.humidity_centi    = hum_q;
	assign res.crc_error         = bad_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosHumCrc)
		else $error("frame position beyond last byte");

	a_frame_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> v_s1)
		else $error("completed frame did not enter frame stage");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (v_s1 && v_s2 && v_q && !res.ready))
		else $error("input stalled with room in the pipeline");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.crc_error) |->
		(res.temperature_centi == '0 && res.humidity_centi == '0))
		else $error("values not cleared on checksum error");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.humidity_centi <= HumSpan))
		else $error("humidity above full scale");

endmodule
